>>> rtl/ndnz_pkg.sv
// Shared definitions for the ND to fractal-NZ address generator.
// Holds register map codes, reset values, default parameters and the config bundle type.
// No dependencies.
`default_nettype none

package ndnz_pkg;

    // Default structural parameters.
    localparam int DEF_DIM_BITS  = 16;
    localparam int DEF_ADDR_BITS = 32;
    localparam int DEF_ELEM_BITS = 64;

    // Fixed widths of the configuration registers.
    localparam int COUNT_W  = 16;
    localparam int BW_W     = 7;
    localparam int STRIDE_W = 32;
    localparam int ESZ_W    = 2;
    localparam int CIB_W    = 6;

    // APB port geometry: seven 32-bit registers at byte address 4*i.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REGIDX_W = 3;

    // Register indexes.
    localparam logic [REGIDX_W-1:0] REG_BATCH_COUNT  = 3'd0;
    localparam logic [REGIDX_W-1:0] REG_ROW_COUNT    = 3'd1;
    localparam logic [REGIDX_W-1:0] REG_COL_COUNT    = 3'd2;
    localparam logic [REGIDX_W-1:0] REG_BLOCK_WIDTH  = 3'd3;
    localparam logic [REGIDX_W-1:0] REG_BLOCK_STRIDE = 3'd4;
    localparam logic [REGIDX_W-1:0] REG_BATCH_STRIDE = 3'd5;
    localparam logic [REGIDX_W-1:0] REG_ELEM_SIZE    = 3'd6;

    // Reset values.
    localparam logic [COUNT_W-1:0]  RST_BATCH_COUNT  = 16'd1;
    localparam logic [COUNT_W-1:0]  RST_ROW_COUNT    = 16'd1;
    localparam logic [COUNT_W-1:0]  RST_COL_COUNT    = 16'd1;
    localparam logic [BW_W-1:0]     RST_BLOCK_WIDTH  = 7'd16;
    localparam logic [STRIDE_W-1:0] RST_BLOCK_STRIDE = 32'd256;
    localparam logic [STRIDE_W-1:0] RST_BATCH_STRIDE = 32'd256;
    localparam logic [ESZ_W-1:0]    RST_ELEM_SIZE    = 2'd1;

    // Largest usable block width.
    localparam logic [BW_W-1:0] MAX_BLOCK_WIDTH = 7'd64;

    // Configuration bundle handed from the register file to the walker.
    typedef struct packed {
        logic [COUNT_W-1:0]  batch_count;
        logic [COUNT_W-1:0]  row_count;
        logic [COUNT_W-1:0]  col_count;
        logic [BW_W-1:0]     block_width;
        logic [STRIDE_W-1:0] block_stride;
        logic [STRIDE_W-1:0] batch_stride;
        logic [ESZ_W-1:0]    elem_size_log2;
    } t_walk_cfg;

endpackage

`default_nettype wire

>>> rtl/ndnz_walker.sv
// Tensor walker: running indices and bases for the ND to NZ address calculation.
// Depends on ndnz_pkg for the config bundle type and register widths.
`default_nettype none

module ndnz_walker
    import ndnz_pkg::*;
#(
    parameter int DIM_BITS  = DEF_DIM_BITS,
    parameter int ADDR_BITS = DEF_ADDR_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_step,
    input  wire t_walk_cfg            i_cfg,
    output logic [ADDR_BITS-1:0]      o_byte_addr,
    output logic                      o_last
);

    // Compare width wide enough for both an index plus one and a count.
    localparam int CMP_W = ((DIM_BITS > COUNT_W) ? DIM_BITS : COUNT_W) + 1;

    logic [DIM_BITS-1:0]  r_batch_index, n_batch_index;
    logic [DIM_BITS-1:0]  r_row_index,   n_row_index;
    logic [DIM_BITS-1:0]  r_col_index,   n_col_index;
    logic [CIB_W-1:0]     r_col_in_block, n_col_in_block;
    logic [ADDR_BITS-1:0] r_batch_base,  n_batch_base;
    logic [ADDR_BITS-1:0] r_row_base,    n_row_base;
    logic [ADDR_BITS-1:0] r_block_base,  n_block_base;

    logic [COUNT_W-1:0]   eff_batch, eff_row, eff_col;
    logic [BW_W-1:0]      eff_bw;
    logic                 col_end, row_end, batch_end, blk_end;
    logic [ADDR_BITS-1:0] elem_off;

    always_comb begin
        eff_batch = (i_cfg.batch_count == '0) ? COUNT_W'(1) : i_cfg.batch_count;
        eff_row   = (i_cfg.row_count == '0)   ? COUNT_W'(1) : i_cfg.row_count;
        eff_col   = (i_cfg.col_count == '0)   ? COUNT_W'(1) : i_cfg.col_count;
        priority if (i_cfg.block_width == '0) begin
            eff_bw = BW_W'(1);
        end else if (i_cfg.block_width > MAX_BLOCK_WIDTH) begin
            eff_bw = MAX_BLOCK_WIDTH;
        end else begin
            eff_bw = i_cfg.block_width;
        end
    end

    assign col_end   = (CMP_W'(r_col_index) + CMP_W'(1))   >= CMP_W'(eff_col);
    assign row_end   = (CMP_W'(r_row_index) + CMP_W'(1))   >= CMP_W'(eff_row);
    assign batch_end = (CMP_W'(r_batch_index) + CMP_W'(1)) >= CMP_W'(eff_batch);
    assign blk_end   = (BW_W'(r_col_in_block) + BW_W'(1))  >= eff_bw;
    assign o_last    = col_end && row_end && batch_end;

    // Element offset in the tiled layout, then scaled to bytes.
    assign elem_off    = r_batch_base + r_block_base + r_row_base
                       + ADDR_BITS'(r_col_in_block);
    assign o_byte_addr = elem_off << i_cfg.elem_size_log2;

    always_comb begin
        n_batch_index  = r_batch_index;
        n_row_index    = r_row_index;
        n_col_index    = r_col_index;
        n_col_in_block = r_col_in_block;
        n_batch_base   = r_batch_base;
        n_row_base     = r_row_base;
        n_block_base   = r_block_base;
        priority if (o_last) begin
            n_batch_index  = '0;
            n_row_index    = '0;
            n_col_index    = '0;
            n_col_in_block = '0;
            n_batch_base   = '0;
            n_row_base     = '0;
            n_block_base   = '0;
        end else if (col_end) begin
            n_col_index    = '0;
            n_col_in_block = '0;
            n_block_base   = '0;
            if (row_end) begin
                n_row_index   = '0;
                n_row_base    = '0;
                n_batch_index = r_batch_index + DIM_BITS'(1);
                n_batch_base  = r_batch_base + ADDR_BITS'(i_cfg.batch_stride);
            end else begin
                n_row_index = r_row_index + DIM_BITS'(1);
                n_row_base  = r_row_base + ADDR_BITS'(eff_bw);
            end
        end else begin
            n_col_index = r_col_index + DIM_BITS'(1);
            if (blk_end) begin
                n_col_in_block = '0;
                n_block_base   = r_block_base + ADDR_BITS'(i_cfg.block_stride);
            end else begin
                n_col_in_block = r_col_in_block + CIB_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch_index  <= '0;
            r_row_index    <= '0;
            r_col_index    <= '0;
            r_col_in_block <= '0;
            r_batch_base   <= '0;
            r_row_base     <= '0;
            r_block_base   <= '0;
        end else if (i_step) begin
            r_batch_index  <= n_batch_index;
            r_row_index    <= n_row_index;
            r_col_index    <= n_col_index;
            r_col_in_block <= n_col_in_block;
            r_batch_base   <= n_batch_base;
            r_row_base     <= n_row_base;
            r_block_base   <= n_block_base;
        end
    end

endmodule

`default_nettype wire

>>> rtl/nd_to_fractal_nz_address_gen_top.sv
// Top level of the ND to fractal-NZ address generator: APB registers, stream ports, result register.
// Depends on ndnz_pkg and instantiates ndnz_walker.
`default_nettype none

// The block takes tensor elements in plain row-major order (batch, then row, then column)
// and returns each element together with its byte address in the tiled NZ layout, that is
// (batch * batch_stride + column_block * block_stride + row * block_width + column_in_block)
// shifted left by elem_size_log2, modulo 2^ADDR_BITS. The same address serves as the read
// address for the NZ to ND direction. The final element of the tensor is flagged on tlast,
// after which the walk starts afresh. The address is formed from running bases that are stepped
// by single additions, and one result register sits on the master side, so with the downstream
// side ready one request is accepted and one result delivered in every cycle; each result
// appears in the cycle after its request is accepted. Counts of zero act as one; a block
// width of zero acts as one and above 64 as 64. Registers must be written over the APB port
// only while the stream is idle; the block itself does not enforce this. Writes never reset
// the walk. Padding is not written, so the destination must be cleared beforehand.
module nd_to_fractal_nz_address_gen_top
    import ndnz_pkg::*;
#(
    parameter int DIM_BITS  = DEF_DIM_BITS,
    parameter int ADDR_BITS = DEF_ADDR_BITS,
    parameter int ELEM_BITS = DEF_ELEM_BITS,
    localparam int IN_TDATA_W  = ((ELEM_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((ADDR_BITS + ELEM_BITS + 7) / 8) * 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    // Slave side: element requests.
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // elem_value
    // Master side: results.
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,  // byte_address, out_value
    output logic                        o_m_axis_tlast,  // last_elem

    // APB configuration port.
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [PADDR_W-1:0]     paddr,
    input  wire logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]          prdata,
    output logic                        pready
);

    t_walk_cfg r_cfg;

    logic                  cfg_wr;
    logic [REGIDX_W-1:0]   reg_idx;
    logic                  in_acc;
    logic [ADDR_BITS-1:0]  walk_addr;
    logic                  walk_last;

    logic                  r_out_valid;
    logic [ADDR_BITS-1:0]  r_out_addr;
    logic [ELEM_BITS-1:0]  r_out_value;
    logic                  r_out_last;

    // Register file. A write completes in the access phase; pready is tied high.
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.batch_count    <= RST_BATCH_COUNT;
            r_cfg.row_count      <= RST_ROW_COUNT;
            r_cfg.col_count      <= RST_COL_COUNT;
            r_cfg.block_width    <= RST_BLOCK_WIDTH;
            r_cfg.block_stride   <= RST_BLOCK_STRIDE;
            r_cfg.batch_stride   <= RST_BATCH_STRIDE;
            r_cfg.elem_size_log2 <= RST_ELEM_SIZE;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_BATCH_COUNT:  r_cfg.batch_count    <= pwdata[COUNT_W-1:0];
                REG_ROW_COUNT:    r_cfg.row_count      <= pwdata[COUNT_W-1:0];
                REG_COL_COUNT:    r_cfg.col_count      <= pwdata[COUNT_W-1:0];
                REG_BLOCK_WIDTH:  r_cfg.block_width    <= pwdata[BW_W-1:0];
                REG_BLOCK_STRIDE: r_cfg.block_stride   <= pwdata[STRIDE_W-1:0];
                REG_BATCH_STRIDE: r_cfg.batch_stride   <= pwdata[STRIDE_W-1:0];
                REG_ELEM_SIZE:    r_cfg.elem_size_log2 <= pwdata[ESZ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read-back of the register selected by the address.
    always_comb begin
        unique case (reg_idx)
            REG_BATCH_COUNT:  prdata = PDATA_W'(r_cfg.batch_count);
            REG_ROW_COUNT:    prdata = PDATA_W'(r_cfg.row_count);
            REG_COL_COUNT:    prdata = PDATA_W'(r_cfg.col_count);
            REG_BLOCK_WIDTH:  prdata = PDATA_W'(r_cfg.block_width);
            REG_BLOCK_STRIDE: prdata = PDATA_W'(r_cfg.block_stride);
            REG_BATCH_STRIDE: prdata = PDATA_W'(r_cfg.batch_stride);
            REG_ELEM_SIZE:    prdata = PDATA_W'(r_cfg.elem_size_log2);
            default:          prdata = '0;
        endcase
    end

    // A request is taken whenever the result register is empty or is being emptied in
    // the same cycle, so a stalled result does not stop the slave side more than needed.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    ndnz_walker #(
        .DIM_BITS  (DIM_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_acc),
        .i_cfg       (r_cfg),
        .o_byte_addr (walk_addr),
        .o_last      (walk_last)
    );

    // Result register: valid is control state, the payload loads on each accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_out_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_addr  <= walk_addr;
            r_out_value <= i_s_axis_tdata[ELEM_BITS-1:0];
            r_out_last  <= walk_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out_value, r_out_addr});
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire
